// File: rtl/ftprp_pkg.sv
// Package for the FTP reply parser: parse phases, result kinds, character
// constants and the state and result structs shared by the step logic and top.
// No dependencies.
package ftprp_pkg;

	localparam int unsigned CodeLen  = 3;
	localparam logic [2:0]  CountMax = 3'd7;

	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChDash    = 8'h2d;
	localparam logic [7:0] ChNewline = 8'h0a;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;

	typedef enum logic [1:0] {
		PH_CODE   = 2'd0,
		PH_MIDDLE = 2'd1,
		PH_LAST   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_INFO     = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_FMT_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t        phase;
		logic [2:0]    count;
		logic [2:0][3:0] digits;
	} parse_state_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] info_byte;
		logic [9:0] reply_code;
	} result_t;

endpackage

// File: rtl/ftprp_core_top_placeholder.sv
// Top level of the FTP reply parser: input register, parser state and result register.
// Depends on ftprp_pkg and ftprp_step.
//
// Usage: received bytes of an FTP control connection enter on the input channel
// (in_valid, in_stall, rx_byte), one transfer per byte. Each byte yields at most
// one result on the output channel (out_valid, out_stall, kind, info_byte,
// reply_code): a text byte when keep_info is set, a completed reply code at the
// newline of the last line, or a format error when a delimiter follows other than
// three digits.
// An input transfer reaches its result through the input register, then the result
// register, where the parser state is updated. Throughput is one byte per cycle
// while in_stall is low; a byte may enter while a result still waits.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall then rises until the result is taken.
// keep_info is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the parser is idle; the block does not enforce it. Reset clears the parser
// to the code phase, keep_info to 0 and both registers to empty.
module ftp_reply_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] info_byte,
	output logic [9:0] reply_code
);

	logic                    keep_info_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	ftprp_pkg::parse_state_t state_q;
	ftprp_pkg::parse_state_t state_nxt;
	ftprp_pkg::result_t      res_nxt;
	ftprp_pkg::result_t      res_q;
	logic                    adv;
	logic                    load_s1;

	// The input stage moves on whenever the result register is empty or unloading.
	assign adv      = !res_q.valid || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign load_s1  = in_valid && !in_stall;

	ftprp_step u_step (
		.cur       (state_q),
		.rx_byte   (byte_s1),
		.keep_info (keep_info_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_info_q <= 1'b0;
		end else if (cfg_wr_en) begin
			keep_info_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || adv) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: ftprp_pkg::PH_CODE, count: 3'd0, digits: '0};
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (adv) begin
			if (valid_s1) begin
				res_q <= res_nxt;
			end else begin
				res_q.valid <= 1'b0;
			end
		end
	end

	assign out_valid  = res_q.valid;
	assign kind       = res_q.kind;
	assign info_byte  = res_q.info_byte;
	assign reply_code = res_q.reply_code;

endmodule

// File: rtl/ftprp_step.sv
// Next-state and result logic of the FTP reply parser for one received byte.
// Depends on ftprp_pkg.
module ftprp_step (
	input  ftprp_pkg::parse_state_t cur,
	input  logic [7:0]              rx_byte,
	input  logic                    keep_info,
	output ftprp_pkg::parse_state_t nxt,
	output ftprp_pkg::result_t      res
);

	logic [3:0]  next_digit;
	logic [10:0] code_sum;
	logic        full_match;
	logic        is_digit;

	assign next_digit = cur.digits[cur.count[1:0]];
	assign full_match = (cur.count == 3'(ftprp_pkg::CodeLen));
	assign is_digit   = (rx_byte >= ftprp_pkg::ChZero) && (rx_byte <= ftprp_pkg::ChNine);

	// d0*100 + d1*10 + d2 with shifts: 100 = 64+32+4, 10 = 8+2.
	assign code_sum = ({7'd0, cur.digits[0]} << 6) + ({7'd0, cur.digits[0]} << 5)
			+ ({7'd0, cur.digits[0]} << 2) + ({7'd0, cur.digits[1]} << 3)
			+ ({7'd0, cur.digits[1]} << 1) + {7'd0, cur.digits[2]};

	always_comb begin
		nxt = cur;
		res = '0;
		res.kind = ftprp_pkg::KIND_INFO;
		case (cur.phase)
			ftprp_pkg::PH_MIDDLE: begin
				if (full_match && rx_byte == ftprp_pkg::ChSpace) begin
					nxt.phase = ftprp_pkg::PH_LAST;
				end else if (!full_match && cur.count < 3'(ftprp_pkg::CodeLen)
						&& rx_byte == (ftprp_pkg::ChZero + {4'd0, next_digit})) begin
					nxt.count = cur.count + 3'd1;
				end else begin
					// Broken match: the byte is reply text.
					nxt.count = '0;
					res.valid = keep_info;
					res.info_byte = rx_byte;
				end
			end
			ftprp_pkg::PH_LAST: begin
				if (rx_byte == ftprp_pkg::ChNewline) begin
					nxt = '0;
					nxt.phase = ftprp_pkg::PH_CODE;
					res.valid = 1'b1;
					res.kind = ftprp_pkg::KIND_COMPLETE;
					res.reply_code = code_sum[9:0];
				end else begin
					res.valid = keep_info;
					res.info_byte = rx_byte;
				end
			end
			default: begin
				// Code phase; the unused phase value behaves the same way.
				nxt.phase = ftprp_pkg::PH_CODE;
				if (rx_byte == ftprp_pkg::ChSpace || rx_byte == ftprp_pkg::ChDash) begin
					if (!full_match) begin
						nxt = '0;
						nxt.phase = ftprp_pkg::PH_CODE;
						res.valid = 1'b1;
						res.kind = ftprp_pkg::KIND_FMT_ERR;
					end else if (rx_byte == ftprp_pkg::ChSpace) begin
						nxt.phase = ftprp_pkg::PH_LAST;
					end else begin
						nxt.phase = ftprp_pkg::PH_MIDDLE;
						nxt.count = '0;
					end
				end else if (is_digit) begin
					if (cur.count < 3'(ftprp_pkg::CodeLen)) begin
						nxt.digits[cur.count[1:0]] = 4'(rx_byte - ftprp_pkg::ChZero);
					end
					if (cur.count < ftprp_pkg::CountMax) begin
						nxt.count = cur.count + 3'd1;
					end
				end else begin
					nxt.count = '0;
				end
			end
		endcase
	end

endmodule

// File: bench/ftp_reply_parser_core_tb.sv
// Testbench for ftp_reply_parser_core: feeds FTP reply byte streams with random gaps
// and output stalls, predicts every result with a parser of its own and checks in order.
// Depends on ftprp_pkg and the ftp_reply_parser_core RTL.

typedef struct packed {
	ftprp_pkg::kind_t kind;
	logic [7:0]       info;
	logic [9:0]       code;
} reply_item_t;

class reply_scoreboard;
	bit                keep_info;
	ftprp_pkg::phase_t phase;
	logic [2:0]        count;
	logic [3:0]        digits [3];
	reply_item_t       want_q [$];
	int                errors;

	function new();
		keep_info = 1'b0;
		errors = 0;
		restart();
	endfunction

	function void restart();
		phase = ftprp_pkg::PH_CODE;
		count = 3'd0;
		foreach (digits[i]) digits[i] = 4'd0;
	endfunction

	function void report_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function void push(ftprp_pkg::kind_t k, logic [7:0] b, logic [9:0] c);
		reply_item_t it;
		it.kind = k;
		it.info = b;
		it.code = c;
		want_q.push_back(it);
	endfunction

	function void push_text(logic [7:0] b);
		if (keep_info)
			push(ftprp_pkg::KIND_INFO, b, 10'd0);
	endfunction

	// Advances the parser by one accepted byte and queues the result it must produce.
	function void note_byte(logic [7:0] b);
		int code;
		case (phase)
		ftprp_pkg::PH_MIDDLE: begin
			if (count == ftprp_pkg::CodeLen && b == ftprp_pkg::ChSpace) begin
				phase = ftprp_pkg::PH_LAST;
			end else if (count < ftprp_pkg::CodeLen &&
				b == ftprp_pkg::ChZero + digits[count]) begin
				count++;
			end else begin
				count = 3'd0;
				push_text(b);
			end
		end
		ftprp_pkg::PH_LAST: begin
			if (b == ftprp_pkg::ChNewline) begin
				code = digits[0] * 100 + digits[1] * 10 + digits[2];
				restart();
				push(ftprp_pkg::KIND_COMPLETE, 8'd0, code[9:0]);
			end else begin
				push_text(b);
			end
		end
		default: begin
			if (b == ftprp_pkg::ChSpace || b == ftprp_pkg::ChDash) begin
				if (count != ftprp_pkg::CodeLen) begin
					restart();
					push(ftprp_pkg::KIND_FMT_ERR, 8'd0, 10'd0);
				end else if (b == ftprp_pkg::ChSpace) begin
					phase = ftprp_pkg::PH_LAST;
				end else begin
					phase = ftprp_pkg::PH_MIDDLE;
					count = 3'd0;
				end
			end else if (b >= ftprp_pkg::ChZero && b <= ftprp_pkg::ChNine) begin
				if (count < ftprp_pkg::CodeLen)
					digits[count] = 4'(b - ftprp_pkg::ChZero);
				if (count < ftprp_pkg::CountMax)
					count++;
			end else begin
				count = 3'd0;
			end
		end
		endcase
	endfunction

	function void check_result(logic [1:0] k, logic [7:0] b, logic [9:0] c);
		reply_item_t w;
		if (want_q.size() == 0) begin
			report_error($sformatf("unexpected result: kind %0d info 0x%02h code %0d",
				k, b, c));
			return;
		end
		w = want_q.pop_front();
		if (k !== w.kind || b !== w.info || c !== w.code)
			report_error($sformatf(
				"expected kind %0d info 0x%02h code %0d, got kind %0d info 0x%02h code %0d",
				w.kind, w.info, w.code, k, b, c));
	endfunction
endclass

module ftp_reply_parser_core_tb;

	localparam int HalfPeriod    = 10;
	localparam int SettleCycles  = 8;
	localparam int TimeoutCycles = 1000000;
	localparam int ItemsPerPhase = 370;
	localparam int NumPhases     = 5;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte     = 8'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [1:0] kind;
	logic [7:0] info_byte;
	logic [9:0] reply_code;

	reply_scoreboard sb = new();
	int sent       = 0;
	int stall_left = 0;
	bit gap_on     = 1'b0;
	bit stall_on   = 1'b0;

	ftp_reply_parser_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.info_byte   (info_byte),
		.reply_code  (reply_code)
	);

	always #(HalfPeriod) clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 2);
		if (r < 19)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(kind, info_byte, reply_code);
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (gap_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic send_digits(input int code, input int n);
		int d;
		for (int i = 0; i < n; i++) begin
			d = (i == 0) ? code / 100 : (i == 1) ? (code / 10) % 10 : code % 10;
			send_byte(ftprp_pkg::ChZero + 8'(d));
		end
	endtask

	// Printable text, or any byte at all when raw is set; never a newline.
	task automatic send_text(input int n, input bit raw);
		logic [7:0] b;
		repeat (n) begin
			b = raw ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7e));
			if (b == ftprp_pkg::ChNewline)
				b = ~b;
			send_byte(b);
		end
	endtask

	task automatic send_reply();
		int code;
		bit raw;
		code = $urandom_range(0, 999);
		raw = ($urandom_range(0, 3) == 0);
		send_digits(code, ftprp_pkg::CodeLen);
		if ($urandom_range(0, 2) == 0) begin
			send_byte(ftprp_pkg::ChSpace);
		end else begin
			send_byte(ftprp_pkg::ChDash);
			// Middle lines often open with part or all of the code to exercise the match.
			repeat ($urandom_range(0, 3)) begin
				send_digits(code, $urandom_range(0, 3));
				send_text($urandom_range(0, 6), raw);
				send_byte(ftprp_pkg::ChNewline);
			end
			send_digits(code, ftprp_pkg::CodeLen);
			send_byte(ftprp_pkg::ChSpace);
		end
		send_text($urandom_range(0, 8), raw);
		send_byte(ftprp_pkg::ChNewline);
	endtask

	task automatic send_broken_code();
		int n;
		n = $urandom_range(0, 8);
		if (n >= ftprp_pkg::CodeLen)
			n++;
		repeat (n) send_byte(ftprp_pkg::ChZero + 8'($urandom_range(0, 9)));
		send_byte(($urandom_range(0, 1) == 1) ? ftprp_pkg::ChSpace : ftprp_pkg::ChDash);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic write_keep_info(input logic v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.keep_info = v;
	endtask

	// Items that produce nothing may still be in the pipeline after the last result.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.want_q.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	initial begin
		repeat (TimeoutCycles) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_keep_info(1'b1);
		// Partial code match then text, full match then a non-space byte,
		// a proper last line with a high text byte, then bad code lengths
		// including a digit run long enough to saturate the counter.
		send_str("999-9x");
		send_str("999");
		send_byte(8'h00);
		send_str("999 ");
		send_byte(8'hff);
		send_byte(ftprp_pkg::ChNewline);
		send_str("12 ");
		send_byte(ftprp_pkg::ChDash);
		send_str("00000000 ");
		wait_idle();

		target = sent;
		for (int p = 0; p < NumPhases; p++) begin
			write_keep_info(p % 2 == 0);
			target += ItemsPerPhase;
			while (sent < target) begin
				gap_on = ($urandom_range(0, 3) != 0);
				stall_on = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 9))
				0: send_broken_code();
				1: send_noise();
				default: send_reply();
				endcase
			end
			wait_idle();
		end

		if (sb.want_q.size() != 0)
			sb.report_error($sformatf("%0d expected results never arrived",
				sb.want_q.size()));
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
